// ----- design/iir_transfer_function_filter_core_assert.svh -----
// Assertion macros used by the filter core sequencer (iirtf_ctrl).
`ifndef IIR_TRANSFER_FUNCTION_FILTER_CORE_ASSERT_SVH
`define IIR_TRANSFER_FUNCTION_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define IIRTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define IIRTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IIRTF_ASSERT_IMP(lbl, ante, cons, msg)
`define IIRTF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/iirtf_pkg.sv -----
// Shared types and constants of the IIR transfer-function filter core.
`default_nettype none

package iirtf_pkg;

  localparam int unsigned ORDER_DEF          = 3;
  localparam int unsigned SAMPLE_WIDTH_DEF   = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 14;

  // coefficient register file: b0..b3 then a0..a3
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_A0 = 3'd4;

  // MAC tap counter, covers 0..2*ORDER for ORDER up to 3
  localparam int unsigned TAP_W = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_MAC_LAST,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic             capture;   // latch sample, clear accumulator
    logic             mul_en;    // multiply tap into product register
    logic [TAP_W-1:0] tap;
    logic             acc_en;    // fold product register into accumulator
    logic             prep;      // take magnitudes for the divider
    logic             check;     // quotient range check
    logic             div_step;  // one restoring division step
    logic             commit;    // write result and histories
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic a0_zero;
    logic quot_ovf;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/iirtf_if.sv -----
// Request and result channel interfaces of the filter core.
`default_nettype none

interface iirtf_in_if
  import iirtf_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface iirtf_out_if
  import iirtf_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           saturated;
  logic                           divide_fault;

  modport source (output valid, output sample_out, output saturated, output divide_fault,
                  input ready);
  modport sink (input valid, input sample_out, input saturated, input divide_fault,
                output ready);
endinterface

`default_nettype wire

// ----- design/iirtf_ctrl.sv -----
// Sequencer of the filter core: MAC pass, range check, division, commit.
`default_nettype none
`include "iir_transfer_function_filter_core_assert.svh"

module iirtf_ctrl
  import iirtf_pkg::*;
#(
  parameter int unsigned ORDER        = ORDER_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  output cmd_t      cmd_o,
  input  wire sts_t sts_i
);

  localparam int unsigned DIV_CNT_W = $clog2(SAMPLE_WIDTH);
  localparam logic [TAP_W-1:0]     LAST_TAP = TAP_W'(2 * ORDER);
  localparam logic [DIV_CNT_W-1:0] LAST_DIV = DIV_CNT_W'(SAMPLE_WIDTH - 1);

  state_e                state_q, state_d;
  logic [TAP_W-1:0]      tap_q, tap_d;
  logic [DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      tap_q     <= tap_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // next state and counters
  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    div_cnt_d = div_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        tap_d = '0;
        if (req_valid_i) state_d = ST_MAC;
      end
      ST_MAC: begin
        if (tap_q == LAST_TAP) state_d = ST_MAC_LAST;
        else tap_d = tap_q + TAP_W'(1);
      end
      ST_MAC_LAST: state_d = ST_PREP;
      ST_PREP:     state_d = ST_CHECK;
      ST_CHECK: begin
        div_cnt_d = '0;
        // zero divisor or out-of-range quotient needs no division
        if (sts_i.a0_zero || sts_i.quot_ovf) state_d = ST_COMMIT;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == LAST_DIV) state_d = ST_COMMIT;
        else div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
      end
      ST_COMMIT: begin
        if (sts_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.tap   = tap_q;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      ST_MAC: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.acc_en = (tap_q != '0);
      end
      ST_MAC_LAST: cmd_o.acc_en   = 1'b1;
      ST_PREP:     cmd_o.prep     = 1'b1;
      ST_CHECK:    cmd_o.check    = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_COMMIT:   cmd_o.commit   = sts_i.slot_free;
      default: ;
    endcase
  end

  `IIRTF_ASSERT_NXT(a_capture_starts_mac, cmd_o.capture, state_q == ST_MAC && tap_q == '0, "capture did not start the MAC pass at tap zero")
  `IIRTF_ASSERT_IMP(a_commit_needs_slot, cmd_o.commit, sts_i.slot_free, "result committed while output register still held")
  `IIRTF_ASSERT_NXT(a_commit_to_idle, cmd_o.commit, state_q == ST_IDLE && req_ready_o, "no return to idle after commit")
  `IIRTF_ASSERT_NXT(a_fault_skips_div, state_q == ST_CHECK && sts_i.a0_zero, state_q == ST_COMMIT, "zero divisor entered the division loop")

endmodule

`default_nettype wire

// ----- design/iirtf_datapath.sv -----
// Datapath of the filter core: coefficients, histories, shared MAC, divider, result.
`default_nettype none

module iirtf_datapath
  import iirtf_pkg::*;
#(
  parameter int unsigned ORDER          = ORDER_DEF,
  parameter int unsigned SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [REG_IDX_W-1:0]                cfg_idx_i,
  input  wire logic [COEF_FRAC_BITS+3:0]           cfg_data_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      req_sample_i,
  input  wire cmd_t                                cmd_i,
  output sts_t                                     sts_o,
  input  wire logic                                rsp_ready_i,
  output logic                                     rsp_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0]           rsp_sample_o,
  output logic                                     rsp_sat_o,
  output logic                                     rsp_fault_o
);

  localparam int unsigned CW     = COEF_FRAC_BITS + 4;
  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned PROD_W = CW + SW;
  // up to seven products, three guard bits
  localparam int unsigned ACC_W  = PROD_W + 3;

  localparam logic [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;
  localparam logic [SW-1:0] S_MAX    = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN    = {1'b1, {(SW-1){1'b0}}};

  logic        [CW-1:0]     coef_q [NUM_REGS];
  logic signed [SW-1:0]     xh_q   [ORDER];
  logic signed [SW-1:0]     yh_q   [ORDER];

  logic signed [SW-1:0]     x_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_sub_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic        [ACC_W-1:0]  rem_q;
  logic        [ACC_W-1:0]  dsr_q;
  logic        [SW-1:0]     quo_q;
  logic                     neg_q;
  logic                     acc_neg_q;
  logic                     ovf_q;

  logic                     out_valid_q;
  logic        [SW-1:0]     out_sample_q;
  logic                     out_sat_q;
  logic                     out_fault_q;

  logic        [REG_IDX_W-1:0] coef_idx;
  logic signed [CW-1:0]        coef_sel;
  logic signed [SW-1:0]        samp_sel;
  logic signed [PROD_W-1:0]    prod_d;
  logic        [CW-1:0]        a0;
  logic        [CW-1:0]        a0_mag;
  logic        [ACC_W-1:0]     acc_mag;
  logic                        rem_ge;
  logic                        a0_zero;
  logic                        slot_free;
  logic        [SW-1:0]        y;
  logic                        y_sat;

  // tap select: b taps first, then a taps (subtracted)
  always_comb begin
    if (cmd_i.tap <= TAP_W'(ORDER)) coef_idx = REG_IDX_W'(cmd_i.tap);
    else coef_idx = REG_IDX_W'(cmd_i.tap + TAP_W'(int'(REG_A0) - int'(ORDER)));
    coef_sel = coef_q[coef_idx];
    samp_sel = x_q;
    for (int i = 0; i < ORDER; i++) begin
      if (cmd_i.tap == TAP_W'(i + 1))         samp_sel = xh_q[i];
      if (cmd_i.tap == TAP_W'(ORDER + i + 1)) samp_sel = yh_q[i];
    end
  end

  assign prod_d = coef_sel * samp_sel;

  assign a0      = coef_q[REG_A0];
  assign a0_zero = (a0 == '0);
  assign a0_mag  = a0[CW-1] ? CW'(-a0) : a0;
  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign rem_ge  = (rem_q >= dsr_q);

  // final value: divide fault, overflow, or signed quotient with clipping
  always_comb begin
    y_sat = 1'b0;
    if (a0_zero) begin
      y = acc_neg_q ? S_MIN : S_MAX;
    end else if (ovf_q) begin
      y     = neg_q ? S_MIN : S_MAX;
      y_sat = 1'b1;
    end else if (neg_q) begin
      y_sat = quo_q[SW-1] && (|quo_q[SW-2:0]);
      y     = y_sat ? S_MIN : SW'(-quo_q);
    end else begin
      y_sat = quo_q[SW-1];
      y     = y_sat ? S_MAX : quo_q;
    end
  end

  assign slot_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    sts_o.slot_free = slot_free;
    sts_o.a0_zero   = a0_zero;
    sts_o.quot_ovf  = rem_ge;
  end

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_q[i] <= ((i == int'(REG_B0)) || (i == int'(REG_A0))) ? COEF_ONE : '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // histories, newest at index zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ORDER; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      xh_q[0] <= x_q;
      yh_q[0] <= y;
      for (int i = 1; i < ORDER; i++) begin
        xh_q[i] <= xh_q[i-1];
        yh_q[i] <= yh_q[i-1];
      end
    end
  end

  // MAC and divider working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q   <= req_sample_i;
      acc_q <= '0;
    end
    if (cmd_i.mul_en) begin
      prod_q     <= prod_d;
      prod_sub_q <= (cmd_i.tap > TAP_W'(ORDER));
    end
    if (cmd_i.acc_en) begin
      if (prod_sub_q) acc_q <= acc_q - ACC_W'(prod_q);
      else acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.prep) begin
      rem_q     <= acc_mag;
      dsr_q     <= ACC_W'(a0_mag) << SW;
      quo_q     <= '0;
      neg_q     <= acc_q[ACC_W-1] ^ a0[CW-1];
      acc_neg_q <= acc_q[ACC_W-1];
    end
    if (cmd_i.check) begin
      ovf_q <= rem_ge;
      dsr_q <= dsr_q >> 1;
    end
    if (cmd_i.div_step) begin
      if (rem_ge) rem_q <= rem_q - dsr_q;
      quo_q <= {quo_q[SW-2:0], rem_ge};
      dsr_q <= dsr_q >> 1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_sample_q <= y;
      out_sat_q    <= y_sat;
      out_fault_q  <= a0_zero;
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign rsp_sample_o = out_sample_q;
  assign rsp_sat_o    = out_sat_q;
  assign rsp_fault_o  = out_fault_q;

endmodule

`default_nettype wire

// ----- design/iir_transfer_function_filter_core.sv -----
// Direct form I IIR filter core: one output sample per input request.
// Usage:
//   - req_i carries one input sample per request; rsp_o returns one result per
//     request: the filtered sample, a saturation flag and a divide fault flag.
//   - Coefficients b0..b3, a0..a3 (signed Q3.14 at default widths) are written
//     through cfg_we_i / cfg_idx_i / cfg_data_i while the core is idle.
//   - Each request runs one shared multiplier over 2*ORDER+1 taps, then a
//     restoring divider by a0 that yields one quotient bit per cycle.
// Sequencing:
//   - From accept to result valid the core runs the MAC pass, takes the
//     magnitudes, checks the quotient range, divides and commits; the divider
//     is skipped on a zero a0 or an out-of-range quotient.
//   - A new request is taken only once the previous one has committed, at
//     a pace set by the serial divider and the single multiplier.
// Reset:
//   - rst_ni clears both sample histories, the sequencer and the output valid;
//     b0 and a0 reset to 1.0, the other coefficients to zero.
// Back-pressure:
//   - The result sits in an output register; the core accepts and computes the
//     next request meanwhile, holding its result until that register drains.
`default_nettype none

module iir_transfer_function_filter_core
  import iirtf_pkg::*;
#(
  parameter int unsigned ORDER          = ORDER_DEF,
  parameter int unsigned SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [REG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [COEF_FRAC_BITS+3:0]   cfg_data_i,
  iirtf_in_if.sink                         req_i,
  iirtf_out_if.source                      rsp_o
);

  cmd_t cmd;
  sts_t sts;

  iirtf_ctrl #(
    .ORDER        (ORDER),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  iirtf_datapath #(
    .ORDER          (ORDER),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_sample_i (req_i.sample_in),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_sample_o (rsp_o.sample_out),
    .rsp_sat_o    (rsp_o.saturated),
    .rsp_fault_o  (rsp_o.divide_fault)
  );

endmodule

`default_nettype wire

// ----- dv/tb_iir_transfer_function_filter_core.sv -----
// Self-checking testbench of the direct form I IIR filter core.
`default_nettype none

module tb_iir_transfer_function_filter_core
  import iirtf_pkg::*;
();

  localparam int unsigned SW = SAMPLE_WIDTH_DEF;
  localparam int unsigned CW = COEF_FRAC_BITS_DEF + 4;
  localparam int          COEF_ONE = 1 << COEF_FRAC_BITS_DEF;
  localparam int          COEF_MAX = (1 << (CW - 1)) - 1;
  localparam int          COEF_MIN = -(1 << (CW - 1));
  localparam longint      SMAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint      SMIN = -(longint'(1) << (SW - 1));
  localparam int          SETTLE_CYCLES = 32;   // a little over accept-to-result
  localparam int          HOLDOFF_CYCLES = 300; // long enough to back up the core
  localparam int          RAND_PHASES = 9;
  localparam int          PHASE_ITEMS = 48;

  typedef logic signed [CW-1:0] coef_t;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 sat;
    logic                 fault;
  } filt_out_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [REG_IDX_W-1:0]   cfg_idx_i;
  logic [CW-1:0]          cfg_data_i;

  iirtf_in_if  req_if ();
  iirtf_out_if rsp_if ();

  iir_transfer_function_filter_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Filter state as the testbench sees it: coefficient copy and the past
  // samples, index k holding the sample k requests back.
  coef_t  coef_val [NUM_REGS];
  coef_t  coef_plan[NUM_REGS];
  longint in_past  [1:ORDER_DEF];
  longint out_past [1:ORDER_DEF];

  logic signed [SW-1:0] pending_samples[$];
  filt_out_t            filter_expect_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int holdoff_req;
  int holdoff_ack;
  int hold_left;
  int mismatch_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("iir_transfer_function_filter_core: mismatch");
    $finish;
  end

  // One filter step: exact sum of products, divide by a0 truncating toward
  // zero, clip to the sample range. A zero a0 gives full scale by the sign
  // of the sum and raises the fault instead.
  function automatic filt_out_t predict_filter_step(input logic signed [SW-1:0] x);
    filt_out_t res;
    longint    acc;
    longint    a0;
    longint    q;
    int        k;
    acc = longint'(coef_val[REG_B0]) * longint'(x);
    for (k = 1; k <= ORDER_DEF; k++) begin
      acc += longint'(coef_val[REG_B0 + k]) * in_past[k];
      acc -= longint'(coef_val[REG_A0 + k]) * out_past[k];
    end
    a0 = longint'(coef_val[REG_A0]);
    res.sat = 1'b0;
    res.fault = 1'b0;
    if (a0 == 0) begin
      res.fault = 1'b1;
      q = (acc >= 0) ? SMAX : SMIN;
    end else begin
      q = acc / a0;
      if (q > SMAX) begin
        q = SMAX;
        res.sat = 1'b1;
      end else if (q < SMIN) begin
        q = SMIN;
        res.sat = 1'b1;
      end
    end
    res.sample = SW'(q);
    for (k = ORDER_DEF; k > 1; k--) begin
      in_past[k] = in_past[k-1];
      out_past[k] = out_past[k-1];
    end
    in_past[1] = longint'(x);
    out_past[1] = q;
    return res;
  endfunction

  // Request driver; also predicts each accepted request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.sample_in <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        filter_expect_q.push_back(predict_filter_step(req_if.sample_in));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.sample_in <= pending_samples.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure, including the long hold-off.
  always @(posedge clk_i) begin
    filt_out_t exp_res;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left <= 0;
      holdoff_ack <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (filter_expect_q.size() == 0) begin
          $display("%0t unexpected result: sample_out %0d saturated %0b divide_fault %0b",
                   $time, rsp_if.sample_out, rsp_if.saturated, rsp_if.divide_fault);
          mismatch_cnt++;
        end else begin
          exp_res = filter_expect_q.pop_front();
          if (rsp_if.sample_out !== exp_res.sample) begin
            $display("%0t sample_out: expected %0d actual %0d",
                     $time, exp_res.sample, rsp_if.sample_out);
            mismatch_cnt++;
          end
          if (rsp_if.saturated !== exp_res.sat) begin
            $display("%0t saturated: expected %0b actual %0b",
                     $time, exp_res.sat, rsp_if.saturated);
            mismatch_cnt++;
          end
          if (rsp_if.divide_fault !== exp_res.fault) begin
            $display("%0t divide_fault: expected %0b actual %0b",
                     $time, exp_res.fault, rsp_if.divide_fault);
            mismatch_cnt++;
          end
        end
      end
      if (holdoff_req != holdoff_ack) begin
        holdoff_ack <= holdoff_req;
        hold_left <= HOLDOFF_CYCLES;
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Write the planned coefficient set, one register per cycle; core idle.
  task automatic apply_coef_plan();
    int i;
    for (i = 0; i < NUM_REGS; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= REG_IDX_W'(i);
      cfg_data_i <= coef_plan[i];
      coef_val[i] = coef_plan[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic plan_coefs(input int b0, input int b1, input int b2, input int b3,
                            input int a0, input int a1, input int a2, input int a3);
    coef_plan[REG_B0]     = coef_t'(b0);
    coef_plan[REG_B0 + 1] = coef_t'(b1);
    coef_plan[REG_B0 + 2] = coef_t'(b2);
    coef_plan[REG_B0 + 3] = coef_t'(b3);
    coef_plan[REG_A0]     = coef_t'(a0);
    coef_plan[REG_A0 + 1] = coef_t'(a1);
    coef_plan[REG_A0 + 2] = coef_t'(a2);
    coef_plan[REG_A0 + 3] = coef_t'(a3);
    apply_coef_plan();
  endtask

  // Wait until every request is taken and every result is back.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || req_if.valid || filter_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom_range(1) ? SW'(SMAX) : SW'(SMIN);
    if (sel == 1) return SW'(int'($urandom_range(64)) - 32);
    return SW'($urandom);
  endfunction

  initial begin
    int p;
    int i;
    int a0;
    // known values from time zero; reset values of the filter state
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.sample_in = '0;
    rsp_if.ready = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 48;
    holdoff_req = 0;
    mismatch_cnt = 0;
    for (i = 0; i < NUM_REGS; i++) coef_val[i] = '0;
    coef_val[REG_B0] = coef_t'(COEF_ONE);
    coef_val[REG_A0] = coef_t'(COEF_ONE);
    for (i = 1; i <= ORDER_DEF; i++) begin
      in_past[i] = 0;
      out_past[i] = 0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset coefficients pass samples straight through
    pending_samples = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sd1, -16'sd1,
                        16'sh5555, 16'shaaaa};
    drain();

    // stable low-order filter driven hard at both rails
    plan_coefs(COEF_ONE / 2, COEF_ONE / 4, -COEF_ONE / 4, COEF_ONE / 8,
               COEF_ONE, -COEF_ONE / 2, COEF_ONE / 4, -COEF_ONE / 8);
    pending_samples = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000};
    drain();

    // zero divisor: positive sum, negative sum, and a zero sum
    plan_coefs(COEF_ONE, 0, 0, 0, 0, 0, 0, 0);
    pending_samples = '{16'sd5, -16'sd5, 16'sd0};
    drain();

    // smallest divisor pushes the quotient far out of range
    plan_coefs(COEF_ONE, 0, 0, 0, 1, 0, 0, 0);
    pending_samples = '{16'sd100, -16'sd100};
    drain();

    // every register at its top, then at its bottom
    plan_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
               COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    pending_samples = '{16'sh7fff, 16'sh8000, 16'sh7fff};
    drain();
    plan_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
               COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    pending_samples = '{16'sh8000, 16'sh7fff, 16'sd0};
    drain();

    // random coefficient sets; receiver idling more, then the sender,
    // then neither
    for (p = 0; p < RAND_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 48;
      end else if (p < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      a0 = int'($urandom_range(COEF_MAX, 1));
      if ($urandom_range(1)) a0 = -a0;
      case (p % 4)
        0: begin
          // anything goes, mostly saturating
          for (i = 0; i < NUM_REGS; i++) coef_plan[i] = coef_t'($urandom);
        end
        1: begin
          // unity divisor, taps within +-1.0, gentle feedback
          for (i = 0; i <= ORDER_DEF; i++)
            coef_plan[REG_B0 + i] = coef_t'(int'($urandom_range(2 * COEF_ONE)) - COEF_ONE);
          coef_plan[REG_A0] = coef_t'(COEF_ONE);
          for (i = 1; i <= ORDER_DEF; i++)
            coef_plan[REG_A0 + i] = coef_t'(int'($urandom_range(COEF_ONE / 2)) - COEF_ONE / 4);
        end
        2: begin
          // arbitrary divisor of either sign
          for (i = 0; i <= ORDER_DEF; i++)
            coef_plan[REG_B0 + i] = coef_t'(int'($urandom_range(4 * COEF_ONE)) - 2 * COEF_ONE);
          coef_plan[REG_A0] = coef_t'(a0);
          for (i = 1; i <= ORDER_DEF; i++)
            coef_plan[REG_A0 + i] = coef_t'(int'($urandom_range(COEF_ONE / 2)) - COEF_ONE / 4);
        end
        default: begin
          // zero divisor with random taps
          for (i = 0; i < NUM_REGS; i++) coef_plan[i] = coef_t'($urandom);
          coef_plan[REG_A0] = '0;
        end
      endcase
      apply_coef_plan();
      for (i = 0; i < PHASE_ITEMS; i++) pending_samples.push_back(rand_sample());
      // hold the receiver off while requests keep coming
      if (p == 1) holdoff_req++;
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (filter_expect_q.size() != 0) begin
      $display("%0t %0d results never arrived", $time, filter_expect_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("iir_transfer_function_filter_core: match");
    end else begin
      $display("iir_transfer_function_filter_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
